[rtl/fpfa_pkg.sv]
// fixed partition fit allocator: shared types, codes and defaults
// no dependencies; imported by every module of the block
`default_nettype none

package fpfa_pkg;

   // default sizing of the partition row
   localparam int MAX_BLOCKS_DEF = 16;
   localparam int SIZE_BITS_DEF  = 16;

   // fixed field widths of the request and result items
   localparam int ENTRY_INDEX_BITS = 4;
   localparam int SIZE_VALUE_BITS  = 16;
   localparam int BLOCK_INDEX_BITS = 4;
   localparam int FIT_MODE_BITS    = 2;
   localparam int BLOCK_COUNT_BITS = 5;

   // configuration bus
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register indices
   localparam logic REG_FIT_MODE    = 1'b0;
   localparam logic REG_BLOCK_COUNT = 1'b1;

   // register reset values
   localparam logic [FIT_MODE_BITS-1:0]    FIT_MODE_RESET    = 2'd0;
   localparam logic [BLOCK_COUNT_BITS-1:0] BLOCK_COUNT_RESET = 5'd16;

   // fit modes, unused code behaves as first fit
   localparam logic [FIT_MODE_BITS-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_MODE_BITS-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_MODE_BITS-1:0] FIT_WORST = 2'd2;

   // request function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // request payload
   typedef struct packed {
      logic                        func;
      logic [ENTRY_INDEX_BITS-1:0] entry_index;
      logic [SIZE_VALUE_BITS-1:0]  size_value;
      logic                        last_in_run;
   } req_type;

   // result payload
   typedef struct packed {
      logic                        granted;
      logic [BLOCK_INDEX_BITS-1:0] block_index;
   } rsp_type;

   // used-mark update broadcast to every cell
   typedef struct packed {
      logic set;
      logic clear;
   } commit_type;

   // partition load broadcast to every cell
   typedef struct packed {
      logic                        enable;
      logic [ENTRY_INDEX_BITS-1:0] index;
      logic [SIZE_VALUE_BITS-1:0]  size;
   } load_type;

endpackage

`default_nettype wire

[rtl/fpfa_csr.sv]
// configuration registers: fit mode and partition count behind an apb-style port
// depends on fpfa_pkg
`default_nettype none

module fpfa_csr
   import fpfa_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [CSR_DATA_BITS-1:0]    pwdata,
   output logic      [CSR_DATA_BITS-1:0]    prdata,
   output logic                             pready,
   output logic      [FIT_MODE_BITS-1:0]    fit_mode,
   output logic      [BLOCK_COUNT_BITS-1:0] block_count
);

   logic [FIT_MODE_BITS-1:0]    fit_mode_ff, fit_mode_in;
   logic [BLOCK_COUNT_BITS-1:0] block_count_ff, block_count_in;
   logic                        wr_en;
   logic                        reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite;

   // register write decode
   always_comb begin
      fit_mode_in    = fit_mode_ff;
      block_count_in = block_count_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FIT_MODE:    fit_mode_in    = pwdata[FIT_MODE_BITS-1:0];
            REG_BLOCK_COUNT: block_count_in = pwdata[BLOCK_COUNT_BITS-1:0];
            default:         fit_mode_in    = fit_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= FIT_MODE_RESET;
         block_count_ff <= BLOCK_COUNT_RESET;
      end else begin
         fit_mode_ff    <= fit_mode_in;
         block_count_ff <= block_count_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_FIT_MODE:    prdata = CSR_DATA_BITS'(fit_mode_ff);
         REG_BLOCK_COUNT: prdata = CSR_DATA_BITS'(block_count_ff);
         default:         prdata = '0;
      endcase
   end

   assign fit_mode    = fit_mode_ff;
   assign block_count = block_count_ff;

endmodule

`default_nettype wire

[rtl/fpfa_cell.sv]
// one partition cell: holds size and used mark, scores the passing request
// and hands the best candidate so far to the next cell; depends on fpfa_pkg
`default_nettype none

module fpfa_cell
   import fpfa_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF,
   parameter int CELL_INDEX = 0,
   localparam int IDX_BITS  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
)(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [FIT_MODE_BITS-1:0]    fit_mode,
   input  wire logic [BLOCK_COUNT_BITS-1:0] block_count,
   input  wire load_type                    load,
   input  wire commit_type                  commit,
   input  wire logic [IDX_BITS-1:0]         commit_pick,
   input  wire logic                        in_valid,
   input  wire logic                        in_found,
   input  wire logic [IDX_BITS-1:0]         in_pick,
   input  wire logic [SIZE_BITS-1:0]        in_best,
   input  wire logic [SIZE_BITS-1:0]        in_req,
   output logic                             out_valid,
   output logic                             out_found,
   output logic      [IDX_BITS-1:0]         out_pick,
   output logic      [SIZE_BITS-1:0]        out_best,
   output logic      [SIZE_BITS-1:0]        out_req,
   output logic                             used
);

   localparam logic [IDX_BITS-1:0] MY_INDEX = IDX_BITS'(CELL_INDEX);

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic                 used_ff, used_in;
   logic                 valid_ff, valid_in;
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  pick_ff, pick_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic [SIZE_BITS-1:0] req_ff, req_in;
   logic                 in_range;
   logic                 eligible;
   logic                 take;

   // partition size store, written by a load addressed to this cell
   always_comb begin
      size_in = size_ff;
      if (load.enable && (32'(load.index) == 32'(CELL_INDEX)))
         size_in = SIZE_BITS'(load.size);
   end

   // used mark: set on grant to this cell, end-of-run clear wins
   always_comb begin
      used_in = used_ff;
      if (commit.set && (commit_pick == MY_INDEX))
         used_in = 1'b1;
      if (commit.clear)
         used_in = 1'b0;
   end

   // candidate scoring, strict compares keep the lowest index on ties
   assign in_range = (32'(block_count) > 32'(CELL_INDEX));
   assign eligible = in_range && !used_ff && (size_ff >= in_req);
   assign take     = eligible && (!in_found
                     || ((fit_mode == FIT_BEST)  && (size_ff < in_best))
                     || ((fit_mode == FIT_WORST) && (size_ff > in_best)));

   always_comb begin
      valid_in = in_valid;
      found_in = in_found | eligible;
      pick_in  = take ? MY_INDEX : in_pick;
      best_in  = take ? size_ff  : in_best;
      req_in   = in_req;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         valid_ff <= valid_in;
      end
   end

   // payload towards the next cell
   always_ff @(posedge clock) begin
      size_ff  <= size_in;
      found_ff <= found_in;
      pick_ff  <= pick_in;
      best_ff  <= best_in;
      req_ff   <= req_in;
   end

   assign out_valid = valid_ff;
   assign out_found = found_ff;
   assign out_pick  = pick_ff;
   assign out_best  = best_ff;
   assign out_req   = req_ff;
   assign used      = used_ff;

endmodule

`default_nettype wire

[rtl/fixed_partition_fit_allocator.sv]
// fixed partition fit allocator: a request walks a row of MAX_BLOCKS cells,
// one cell per cycle; the result strobe passes the request register, then every cell of the row
// busy holds during the walk, so a new allocation is taken only after the last result
// loads are taken back to back while idle and give no result; results cannot be stalled
// synchronous reset frees every partition and restores the registers;
// partition sizes stay undefined until loaded
`default_nettype none

module fixed_partition_fit_allocator
   import fpfa_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = SIZE_BITS_DEF
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     start,
   input  wire req_type                  req_data,
   output logic                          busy,
   // result channel
   output logic                          rsp_valid,
   output rsp_type                       rsp_data,
   // configuration port
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   localparam int IDX_BITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   logic [FIT_MODE_BITS-1:0]    fit_mode;
   logic [BLOCK_COUNT_BITS-1:0] block_count;

   logic                 accept;
   logic                 start_ff, start_in;
   logic                 last_ff, last_in;
   logic [SIZE_BITS-1:0] req_size_ff, req_size_in;
   load_type             load;
   commit_type           commit;

   // links of the cell row, link 0 fed from the request registers
   logic                 link_valid [0:MAX_BLOCKS];
   logic                 link_found [0:MAX_BLOCKS];
   logic [IDX_BITS-1:0]  link_pick  [0:MAX_BLOCKS];
   logic [SIZE_BITS-1:0] link_best  [0:MAX_BLOCKS];
   logic [SIZE_BITS-1:0] link_req   [0:MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] cell_valid;
   logic [MAX_BLOCKS-1:0] used_vec;

   fpfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .fit_mode    (fit_mode),
      .block_count (block_count)
   );

   // request acceptance
   assign accept = start && !busy;
   assign busy   = start_ff || (|cell_valid);

   always_comb begin
      load.enable = accept && (req_data.func == FUNC_LOAD);
      load.index  = req_data.entry_index;
      load.size   = req_data.size_value;
   end

   always_comb begin
      start_in    = accept && (req_data.func == FUNC_ALLOC);
      last_in     = last_ff;
      req_size_in = req_size_ff;
      if (start_in) begin
         last_in     = req_data.last_in_run;
         req_size_in = SIZE_BITS'(req_data.size_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         start_ff <= 1'b0;
      else
         start_ff <= start_in;
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      req_size_ff <= req_size_in;
   end

   assign link_valid[0] = start_ff;
   assign link_found[0] = 1'b0;
   assign link_pick[0]  = '0;
   assign link_best[0]  = '0;
   assign link_req[0]   = req_size_ff;

   // row of partition cells
   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      fpfa_cell #(
         .MAX_BLOCKS (MAX_BLOCKS),
         .SIZE_BITS  (SIZE_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .fit_mode    (fit_mode),
         .block_count (block_count),
         .load        (load),
         .commit      (commit),
         .commit_pick (link_pick[MAX_BLOCKS]),
         .in_valid    (link_valid[g]),
         .in_found    (link_found[g]),
         .in_pick     (link_pick[g]),
         .in_best     (link_best[g]),
         .in_req      (link_req[g]),
         .out_valid   (link_valid[g+1]),
         .out_found   (link_found[g+1]),
         .out_pick    (link_pick[g+1]),
         .out_best    (link_best[g+1]),
         .out_req     (link_req[g+1]),
         .used        (used_vec[g])
      );
      assign cell_valid[g] = link_valid[g+1];
   end

   // result from the end of the row, and the used-mark update it causes
   assign rsp_valid = link_valid[MAX_BLOCKS];

   always_comb begin
      rsp_data.granted     = link_found[MAX_BLOCKS];
      rsp_data.block_index = link_found[MAX_BLOCKS]
                             ? BLOCK_INDEX_BITS'(link_pick[MAX_BLOCKS]) : '0;
      commit.set           = rsp_valid && link_found[MAX_BLOCKS];
      commit.clear         = rsp_valid && last_ff;
   end

`ifndef SYNTH
   // only one request walks the row at a time
   a_single_walk: assert property (@(posedge clock) disable iff (reset)
      $onehot0({start_ff, cell_valid}))
      else $error("more than one request in the cell row");

   // an accepted allocation holds busy until its result
   a_busy_after_alloc: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_ALLOC)) |=> busy)
      else $error("busy not raised after allocation request");

   // a refused request reports index zero
   a_refusal_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.granted) |-> (rsp_data.block_index == '0))
      else $error("refused request with non-zero index");

   // end of run frees every partition
   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && last_ff) |=> (used_vec == '0))
      else $error("used marks survive end of run");

   // a grant marks its partition used
   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.granted && !last_ff) |=> (used_vec != '0))
      else $error("granted partition not marked used");
`endif

endmodule

`default_nettype wire

[bench/tb_fixed_partition_fit_allocator.sv]
// testbench for the fixed partition fit allocator: loads partition sizes, then sends
// allocation requests under every fit mode and a range of partition counts; depends on fpfa_pkg
// and the fixed_partition_fit_allocator rtl only
`default_nettype none

module tb_fixed_partition_fit_allocator
   import fpfa_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // spare fit mode code, behaves as first fit
   localparam logic [FIT_MODE_BITS-1:0] FIT_SPARE = 2'd3;
   // register byte addresses
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_FIT_MODE    = {REG_FIT_MODE, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_BLOCK_COUNT = {REG_BLOCK_COUNT, 2'b00};
   // walk of the row plus margin, waited out before any register write
   localparam int SETTLE_CYCLES = MAX_BLOCKS_DEF + 4;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_REQUESTS = 73;

   typedef struct {
      req_type payload;
      bit      drain_first;
   } queued_request_type;

   logic                     clock;
   logic                     reset;
   logic                     start = 1'b0;
   req_type                  req_data = '0;
   logic                     busy;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // stimulus queue and expected grants
   queued_request_type pending_requests[$];
   rsp_type            expected_grants[$];
   int                 queued_count = 0;
   int                 accepted_count = 0;
   int                 idle_pct = 0;
   int                 idle_left = 0;

   // allocator image kept by the predictor
   logic [SIZE_VALUE_BITS-1:0]  part_size[MAX_BLOCKS_DEF];
   bit                          part_used[MAX_BLOCKS_DEF];
   logic [FIT_MODE_BITS-1:0]    cfg_fit_mode = FIT_MODE_RESET;
   logic [BLOCK_COUNT_BITS-1:0] cfg_block_count = BLOCK_COUNT_RESET;

   // sizes as the generator will have loaded them
   logic [SIZE_VALUE_BITS-1:0]  plan_size[MAX_BLOCKS_DEF];

   // run statistics
   int failures = 0;
   int loads_seen = 0;
   int allocs_seen = 0;
   int grants_seen = 0;
   int refusals_seen = 0;
   int settings_seen = 1;

   fixed_partition_fit_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // apply one accepted request to the image, queue the grant it should give
   function automatic void predict_fit(input req_type r);
      int      limit;
      int      pick;
      bit      found;
      rsp_type grant;
      found = 1'b0;
      pick = 0;
      if (r.func == FUNC_LOAD) begin
         part_size[r.entry_index] = r.size_value;
         loads_seen++;
         return;
      end
      allocs_seen++;
      limit = (cfg_block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : cfg_block_count;
      for (int j = 0; j < limit; j++) begin
         if (!part_used[j] && part_size[j] >= r.size_value) begin
            if (!found) begin
               found = 1'b1;
               pick = j;
               if (cfg_fit_mode != FIT_BEST && cfg_fit_mode != FIT_WORST) break;
            end else if (cfg_fit_mode == FIT_BEST && part_size[j] < part_size[pick]) begin
               pick = j;
            end else if (cfg_fit_mode == FIT_WORST && part_size[j] > part_size[pick]) begin
               pick = j;
            end
         end
      end
      if (found) part_used[pick] = 1'b1;
      grant.granted = found;
      grant.block_index = found ? BLOCK_INDEX_BITS'(pick) : '0;
      expected_grants.push_back(grant);
      // end of run frees everything after the allocation
      if (r.last_in_run) part_used = '{default: 1'b0};
   endfunction

   // request driver
   always @(posedge clock) begin : drive_requests
      queued_request_type head;
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            predict_fit(req_data);
            accepted_count++;
         end
         if (!start || !busy) begin
            if (idle_left > 0) begin
               start <= 1'b0;
               idle_left <= idle_left - 1;
            end else if (pending_requests.size() == 0 ||
                         (pending_requests[0].drain_first && expected_grants.size() != 0)) begin
               start <= 1'b0;
            end else if ($urandom_range(1, 100) <= idle_pct) begin
               start <= 1'b0;
               idle_left <= $urandom_range(0, 10);
            end else begin
               head = pending_requests.pop_front();
               start <= 1'b1;
               req_data <= head.payload;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : check_grants
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_grants.size() == 0) begin
            $display("%0t: unexpected result, expected none, got granted=%0b index=%0d",
                     $time, rsp_data.granted, rsp_data.block_index);
            failures++;
         end else begin
            want = expected_grants.pop_front();
            if (rsp_data.granted !== want.granted) begin
               $display("%0t: granted mismatch, expected %0b, got %0b",
                        $time, want.granted, rsp_data.granted);
               failures++;
            end
            if (rsp_data.block_index !== want.block_index) begin
               $display("%0t: block_index mismatch, expected %0d, got %0d",
                        $time, want.block_index, rsp_data.block_index);
               failures++;
            end
            if (want.granted) grants_seen++;
            else refusals_seen++;
         end
      end
   end

   // read a register and compare it
   task automatic check_reg(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] want);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $display("%0t: register %0d readback mismatch, expected %0d, got %0d",
                  $time, addr, want, prdata);
         failures++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // write both registers while the allocator is idle, then read them back
   task automatic set_mode_and_count(input logic [FIT_MODE_BITS-1:0] mode,
                                     input logic [BLOCK_COUNT_BITS-1:0] count);
      logic [CSR_ADDR_BITS-1:0] addrs[2];
      logic [CSR_DATA_BITS-1:0] values[2];
      addrs = '{ADDR_FIT_MODE, ADDR_BLOCK_COUNT};
      values = '{CSR_DATA_BITS'(mode), CSR_DATA_BITS'(count)};
      for (int k = 0; k < 2; k++) begin
         @(posedge clock);
         psel <= 1'b1;
         penable <= 1'b0;
         pwrite <= 1'b1;
         paddr <= addrs[k];
         pwdata <= values[k];
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
      end
      cfg_fit_mode = mode;
      cfg_block_count = count;
      settings_seen++;
      check_reg(ADDR_FIT_MODE, CSR_DATA_BITS'(mode));
      check_reg(ADDR_BLOCK_COUNT, CSR_DATA_BITS'(count));
   endtask

   // wait until every request is taken and every grant has come back
   task automatic wait_idle();
      while (accepted_count != queued_count || expected_grants.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_load(input int idx, input logic [SIZE_VALUE_BITS-1:0] size);
      queued_request_type q;
      q.payload.func = FUNC_LOAD;
      q.payload.entry_index = ENTRY_INDEX_BITS'(idx);
      q.payload.size_value = size;
      // last flag is meaningless on a load, randomise it anyway
      q.payload.last_in_run = 1'($urandom_range(0, 1));
      q.drain_first = 1'b0;
      plan_size[idx] = size;
      pending_requests.push_back(q);
      queued_count++;
   endtask

   task automatic queue_alloc(input logic [SIZE_VALUE_BITS-1:0] size, input bit last,
                              input bit drain);
      queued_request_type q;
      q.payload.func = FUNC_ALLOC;
      q.payload.entry_index = ENTRY_INDEX_BITS'($urandom_range(0, 15));
      q.payload.size_value = size;
      q.payload.last_in_run = last;
      q.drain_first = drain;
      pending_requests.push_back(q);
      queued_count++;
   endtask

   // requested sizes, half of them close to loaded partition sizes
   function automatic logic [SIZE_VALUE_BITS-1:0] pick_alloc_size();
      int unsigned base;
      base = plan_size[$urandom_range(0, MAX_BLOCKS_DEF - 1)];
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return SIZE_VALUE_BITS'(base);
         4, 5: return (base > 8) ? SIZE_VALUE_BITS'(base - $urandom_range(1, 8)) : '0;
         6: return (base < 16'hFFFF) ? SIZE_VALUE_BITS'(base + 1) : SIZE_VALUE_BITS'(base);
         7: return SIZE_VALUE_BITS'($urandom_range(0, 300));
         default: return SIZE_VALUE_BITS'($urandom());
      endcase
   endfunction

   // loaded sizes, coarse steps give plenty of ties
   function automatic logic [SIZE_VALUE_BITS-1:0] pick_load_size();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2, 3, 4: return SIZE_VALUE_BITS'(50 * $urandom_range(0, 10));
         default: return SIZE_VALUE_BITS'($urandom());
      endcase
   endfunction

   // timeout
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // reset, directed requests, then random phases
   initial begin : run_phases
      logic [SIZE_VALUE_BITS-1:0]  start_sizes[MAX_BLOCKS_DEF];
      logic [FIT_MODE_BITS-1:0]    modes[4];
      int                          fixed_counts[7];
      int                          phase_idle[RANDOM_PHASES];
      int                          run_left;
      bit                          last;
      logic [BLOCK_COUNT_BITS-1:0] count;
      start_sizes = '{16'd100, 16'd0, 16'hFFFF, 16'd500, 16'd100, 16'd300, 16'hFFFF, 16'd42,
                      16'd7, 16'd1000, 16'd300, 16'd2, 16'd8000, 16'd12, 16'hFFFE, 16'd500};
      modes = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_SPARE};
      fixed_counts = '{16, 1, 0, 31, 17, 16, 4};
      phase_idle = '{0, 25, 10, 50, 0, 15, 35, 5, 20, 40, 10, 0};
      run_left = 0;
      part_used = '{default: 1'b0};
      part_size = '{default: '0};
      plan_size = '{default: '0};

      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers come up at their reset values
      check_reg(ADDR_FIT_MODE, CSR_DATA_BITS'(FIT_MODE_RESET));
      check_reg(ADDR_BLOCK_COUNT, CSR_DATA_BITS'(BLOCK_COUNT_RESET));

      // directed: fill every partition, then first fit with a refusal at end of run
      idle_pct = 20;
      for (int i = 0; i < MAX_BLOCKS_DEF; i++) queue_load(i, start_sizes[i]);
      queue_alloc('0, 1'b0, 1'b0);
      queue_alloc('1, 1'b0, 1'b0);
      queue_alloc('1, 1'b0, 1'b1);
      // load over a used partition keeps it used
      queue_load(0, '1);
      queue_alloc('1, 1'b1, 1'b0);
      wait_idle();

      // directed: best fit with ties, then worst fit
      set_mode_and_count(FIT_BEST, 5'd16);
      queue_alloc(16'd100, 1'b0, 1'b0);
      queue_alloc(16'd100, 1'b0, 1'b0);
      queue_alloc(16'd1, 1'b1, 1'b0);
      wait_idle();
      set_mode_and_count(FIT_WORST, 5'd16);
      queue_alloc('0, 1'b1, 1'b0);
      wait_idle();

      // random phases over modes and partition counts; last phase without idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 7) count = BLOCK_COUNT_BITS'(fixed_counts[p]);
         else if (p == RANDOM_PHASES - 1) count = BLOCK_COUNT_RESET;
         else count = BLOCK_COUNT_BITS'($urandom_range(0, 31));
         set_mode_and_count(modes[p % 4], count);
         idle_pct = phase_idle[p];
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(0, 99) < 20) begin
               queue_load($urandom_range(0, MAX_BLOCKS_DEF - 1), pick_load_size());
            end else begin
               // runs of requests closed by an end-of-run request, a few broken
               if (run_left == 0) run_left = $urandom_range(1, 18);
               last = (run_left == 1);
               if ($urandom_range(0, 29) == 0) last = ~last;
               run_left--;
               queue_alloc(pick_alloc_size(), last, $urandom_range(0, 39) == 0);
            end
         end
         wait_idle();
      end

      $display("covered %0d loads and %0d allocation requests (%0d granted, %0d refused)",
               loads_seen, allocs_seen, grants_seen, refusals_seen);
      $display("across %0d register settings of fit mode and partition count", settings_seen);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/fpfa_pkg.sv
rtl/fpfa_csr.sv
rtl/fpfa_cell.sv
rtl/fixed_partition_fit_allocator.sv
bench/tb_fixed_partition_fit_allocator.sv
